// File: design/lfu_pkg.sv
// Shared types and constants for the LFU store with ghost list.
// Used by lfu_cell and lfu_cache_with_ghost_list; depends on nothing.
`default_nettype none

package lfu_pkg;

    localparam int MAIN_ENTRIES_DEF  = 16;
    localparam int GHOST_ENTRIES_DEF = 8;
    localparam int KEY_BITS_DEF      = 32;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int STAMP_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int GCAP_BITS  = 4;
    localparam int THR_BITS   = 16;
    localparam int REQ_BITS   = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [REQ_BITS-1:0] REQ_GET    = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUT    = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_GROW   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_SHRINK = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_CHECK  = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_CAP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GHOST_CAP = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic clr_en;
        logic wr_en;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/lfu_cache_with_ghost_list.sv
// LFU key/value store with ghost list: top level, request sequencer and config.
// Depends on lfu_pkg and lfu_cell.
//
// Every entry of the main store and of the ghost list sits in a cell of a
// registered chain; a request waits for the chain to settle, then acts on
// the match, count, free slot and eviction victim at the chain's end. Get and
// put hits, get misses, capacity changes and ghost checks take one chain pass.
// A ghost revival or a put of a new key takes a second pass. One request is in
// flight at a time; the result waits in an output register, and the next
// request can be taken in the cycle after the result is loaded. Configuration
// writes are taken in every cycle.
`default_nettype none

module lfu_cache_with_ghost_list #(
    parameter int MAIN_ENTRIES  = lfu_pkg::MAIN_ENTRIES_DEF,
    parameter int GHOST_ENTRIES = lfu_pkg::GHOST_ENTRIES_DEF,
    parameter int KEY_BITS      = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS    = lfu_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS    = lfu_pkg::COUNT_BITS_DEF,
    localparam int S_DATA_W     = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W     = ((VALUE_BITS + lfu_pkg::CAP_BITS + 7) / 8) * 8
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [S_DATA_W-1:0]                 s_tdata,   // key, write_value
    input  wire  [lfu_pkg::REQ_BITS-1:0]        s_tuser,   // req_type
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [M_DATA_W-1:0]                 m_tdata,   // read_value, capacity_now
    output logic [1:0]                          m_tuser,   // found, transform_flag
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [lfu_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [lfu_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int MIDX_W   = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
    localparam int GIDX_W   = (GHOST_ENTRIES > 1) ? $clog2(GHOST_ENTRIES) : 1;
    localparam int MCNT_W   = $clog2(MAIN_ENTRIES + 1);
    localparam int GCNT_W   = $clog2(GHOST_ENTRIES + 1);
    localparam int SCAN_LEN = (MAIN_ENTRIES > GHOST_ENTRIES) ? MAIN_ENTRIES : GHOST_ENTRIES;
    localparam int SCNT_W   = $clog2(SCAN_LEN + 1);
    localparam int SB       = lfu_pkg::STAMP_BITS;
    localparam int CB       = lfu_pkg::CAP_BITS;
    localparam logic [CB-1:0] CAP_RESET = CB'((MAIN_ENTRIES < 16) ? MAIN_ENTRIES : 16);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // main chain
    logic [MCNT_W-1:0]     mc_cnt        [0:MAIN_ENTRIES];
    logic                  mc_free_ok    [0:MAIN_ENTRIES];
    logic [MIDX_W-1:0]     mc_free_idx   [0:MAIN_ENTRIES];
    logic                  mc_hit_ok     [0:MAIN_ENTRIES];
    logic [MIDX_W-1:0]     mc_hit_idx    [0:MAIN_ENTRIES];
    logic [VALUE_BITS-1:0] mc_hit_data   [0:MAIN_ENTRIES];
    logic [COUNT_BITS-1:0] mc_hit_freq   [0:MAIN_ENTRIES];
    logic [COUNT_BITS-1:0] mc_hit_acc    [0:MAIN_ENTRIES];
    logic                  mc_best_ok    [0:MAIN_ENTRIES];
    logic [MIDX_W-1:0]     mc_best_idx   [0:MAIN_ENTRIES];
    logic [KEY_BITS-1:0]   mc_best_key   [0:MAIN_ENTRIES];
    logic [VALUE_BITS-1:0] mc_best_data  [0:MAIN_ENTRIES];
    logic [COUNT_BITS-1:0] mc_best_freq  [0:MAIN_ENTRIES];
    logic [COUNT_BITS-1:0] mc_best_acc   [0:MAIN_ENTRIES];
    logic [SB-1:0]         mc_best_stamp [0:MAIN_ENTRIES];

    // ghost chain
    logic [GCNT_W-1:0]     gc_cnt        [0:GHOST_ENTRIES];
    logic                  gc_free_ok    [0:GHOST_ENTRIES];
    logic [GIDX_W-1:0]     gc_free_idx   [0:GHOST_ENTRIES];
    logic                  gc_hit_ok     [0:GHOST_ENTRIES];
    logic [GIDX_W-1:0]     gc_hit_idx    [0:GHOST_ENTRIES];
    logic [VALUE_BITS-1:0] gc_hit_data   [0:GHOST_ENTRIES];
    logic [COUNT_BITS-1:0] gc_hit_freq   [0:GHOST_ENTRIES];
    logic [COUNT_BITS-1:0] gc_hit_acc    [0:GHOST_ENTRIES];
    logic                  gc_best_ok    [0:GHOST_ENTRIES];
    logic [GIDX_W-1:0]     gc_best_idx   [0:GHOST_ENTRIES];
    logic [KEY_BITS-1:0]   gc_best_key   [0:GHOST_ENTRIES];
    logic [VALUE_BITS-1:0] gc_best_data  [0:GHOST_ENTRIES];
    logic [COUNT_BITS-1:0] gc_best_freq  [0:GHOST_ENTRIES];
    logic [COUNT_BITS-1:0] gc_best_acc   [0:GHOST_ENTRIES];
    logic [SB-1:0]         gc_best_stamp [0:GHOST_ENTRIES];

    // cell write ports
    lfu_pkg::cell_cmd_t    m_cmd;
    logic [MIDX_W-1:0]     m_clr_idx;
    logic [MIDX_W-1:0]     m_wr_idx;
    logic [KEY_BITS-1:0]   m_wr_key;
    logic [VALUE_BITS-1:0] m_wr_data;
    logic [COUNT_BITS-1:0] m_wr_freq;
    logic [COUNT_BITS-1:0] m_wr_acc;
    logic [SB-1:0]         m_wr_stamp;
    lfu_pkg::cell_cmd_t    g_cmd;
    logic [GIDX_W-1:0]     g_clr_idx;
    logic [GIDX_W-1:0]     g_wr_idx;
    logic [SB-1:0]         g_wr_stamp;

    // sequencer state
    logic [1:0]                   state_reg, state_next;
    logic [SCNT_W-1:0]            scan_cnt_reg, scan_cnt_next;
    logic                         phase_reg, phase_next;
    logic [lfu_pkg::REQ_BITS-1:0] req_reg, req_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [VALUE_BITS-1:0]        wv_reg, wv_next;
    logic [VALUE_BITS-1:0]        ins_data_reg, ins_data_next;
    logic [COUNT_BITS-1:0]        ins_freq_reg, ins_freq_next;
    logic [COUNT_BITS-1:0]        ins_acc_reg, ins_acc_next;
    logic                         res_found_reg, res_found_next;
    logic [VALUE_BITS-1:0]        res_rv_reg, res_rv_next;
    logic                         res_tf_reg, res_tf_next;
    logic [SB-1:0]                stamp_reg, stamp_next;
    logic [CB-1:0]                cap_reg, cap_next;
    logic [lfu_pkg::GCAP_BITS-1:0] gcap_reg, gcap_next;
    logic [lfu_pkg::THR_BITS-1:0] thr_reg, thr_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_found_reg, m_found_next;
    logic                         m_tf_reg, m_tf_next;
    logic [VALUE_BITS-1:0]        m_rv_reg, m_rv_next;
    logic [CB-1:0]                m_cap_reg, m_cap_next;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [SB-1:0] stamp_inc(input logic [SB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign mc_cnt[0]        = '0;
    assign mc_free_ok[0]    = 1'b0;
    assign mc_free_idx[0]   = '0;
    assign mc_hit_ok[0]     = 1'b0;
    assign mc_hit_idx[0]    = '0;
    assign mc_hit_data[0]   = '0;
    assign mc_hit_freq[0]   = '0;
    assign mc_hit_acc[0]    = '0;
    assign mc_best_ok[0]    = 1'b0;
    assign mc_best_idx[0]   = '0;
    assign mc_best_key[0]   = '0;
    assign mc_best_data[0]  = '0;
    assign mc_best_freq[0]  = '0;
    assign mc_best_acc[0]   = '0;
    assign mc_best_stamp[0] = '0;

    assign gc_cnt[0]        = '0;
    assign gc_free_ok[0]    = 1'b0;
    assign gc_free_idx[0]   = '0;
    assign gc_hit_ok[0]     = 1'b0;
    assign gc_hit_idx[0]    = '0;
    assign gc_hit_data[0]   = '0;
    assign gc_hit_freq[0]   = '0;
    assign gc_hit_acc[0]    = '0;
    assign gc_best_ok[0]    = 1'b0;
    assign gc_best_idx[0]   = '0;
    assign gc_best_key[0]   = '0;
    assign gc_best_data[0]  = '0;
    assign gc_best_freq[0]  = '0;
    assign gc_best_acc[0]   = '0;
    assign gc_best_stamp[0] = '0;

    genvar i;
    generate
        for (i = 0; i < MAIN_ENTRIES; i++) begin : g_main
            lfu_cell #(
                .ENTRIES(MAIN_ENTRIES), .INDEX(i), .KEY_BITS(KEY_BITS),
                .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS), .USE_FREQ(1'b1)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(m_cmd),
                .clr_idx(m_clr_idx), .wr_idx(m_wr_idx), .wr_key(m_wr_key),
                .wr_data(m_wr_data), .wr_freq(m_wr_freq), .wr_acc(m_wr_acc),
                .wr_stamp(m_wr_stamp), .look_key(key_reg),
                .up_cnt(mc_cnt[i]), .up_free_ok(mc_free_ok[i]),
                .up_free_idx(mc_free_idx[i]), .up_hit_ok(mc_hit_ok[i]),
                .up_hit_idx(mc_hit_idx[i]), .up_hit_data(mc_hit_data[i]),
                .up_hit_freq(mc_hit_freq[i]), .up_hit_acc(mc_hit_acc[i]),
                .up_best_ok(mc_best_ok[i]), .up_best_idx(mc_best_idx[i]),
                .up_best_key(mc_best_key[i]), .up_best_data(mc_best_data[i]),
                .up_best_freq(mc_best_freq[i]), .up_best_acc(mc_best_acc[i]),
                .up_best_stamp(mc_best_stamp[i]),
                .dn_cnt(mc_cnt[i+1]), .dn_free_ok(mc_free_ok[i+1]),
                .dn_free_idx(mc_free_idx[i+1]), .dn_hit_ok(mc_hit_ok[i+1]),
                .dn_hit_idx(mc_hit_idx[i+1]), .dn_hit_data(mc_hit_data[i+1]),
                .dn_hit_freq(mc_hit_freq[i+1]), .dn_hit_acc(mc_hit_acc[i+1]),
                .dn_best_ok(mc_best_ok[i+1]), .dn_best_idx(mc_best_idx[i+1]),
                .dn_best_key(mc_best_key[i+1]), .dn_best_data(mc_best_data[i+1]),
                .dn_best_freq(mc_best_freq[i+1]), .dn_best_acc(mc_best_acc[i+1]),
                .dn_best_stamp(mc_best_stamp[i+1])
            );
        end
        for (i = 0; i < GHOST_ENTRIES; i++) begin : g_ghost
            lfu_cell #(
                .ENTRIES(GHOST_ENTRIES), .INDEX(i), .KEY_BITS(KEY_BITS),
                .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS), .USE_FREQ(1'b0)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(g_cmd),
                .clr_idx(g_clr_idx), .wr_idx(g_wr_idx),
                .wr_key(mc_best_key[MAIN_ENTRIES]),
                .wr_data(mc_best_data[MAIN_ENTRIES]),
                .wr_freq(mc_best_freq[MAIN_ENTRIES]),
                .wr_acc(mc_best_acc[MAIN_ENTRIES]),
                .wr_stamp(g_wr_stamp), .look_key(key_reg),
                .up_cnt(gc_cnt[i]), .up_free_ok(gc_free_ok[i]),
                .up_free_idx(gc_free_idx[i]), .up_hit_ok(gc_hit_ok[i]),
                .up_hit_idx(gc_hit_idx[i]), .up_hit_data(gc_hit_data[i]),
                .up_hit_freq(gc_hit_freq[i]), .up_hit_acc(gc_hit_acc[i]),
                .up_best_ok(gc_best_ok[i]), .up_best_idx(gc_best_idx[i]),
                .up_best_key(gc_best_key[i]), .up_best_data(gc_best_data[i]),
                .up_best_freq(gc_best_freq[i]), .up_best_acc(gc_best_acc[i]),
                .up_best_stamp(gc_best_stamp[i]),
                .dn_cnt(gc_cnt[i+1]), .dn_free_ok(gc_free_ok[i+1]),
                .dn_free_idx(gc_free_idx[i+1]), .dn_hit_ok(gc_hit_ok[i+1]),
                .dn_hit_idx(gc_hit_idx[i+1]), .dn_hit_data(gc_hit_data[i+1]),
                .dn_hit_freq(gc_hit_freq[i+1]), .dn_hit_acc(gc_hit_acc[i+1]),
                .dn_best_ok(gc_best_ok[i+1]), .dn_best_idx(gc_best_idx[i+1]),
                .dn_best_key(gc_best_key[i+1]), .dn_best_data(gc_best_data[i+1]),
                .dn_best_freq(gc_best_freq[i+1]), .dn_best_acc(gc_best_acc[i+1]),
                .dn_best_stamp(gc_best_stamp[i+1])
            );
        end
    endgenerate

    always_comb begin
        logic [COUNT_BITS-1:0] acc;
        logic [GCNT_W-1:0]     g_lim;
        logic                  evict;
        logic                  drop;
        logic                  g_slot_ok;
        logic [GIDX_W-1:0]     g_slot;
        logic                  m_slot_ok;
        logic [MIDX_W-1:0]     m_slot;
        logic [SB-1:0]         stamp_a;

        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        phase_next    = phase_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        wv_next       = wv_reg;
        ins_data_next = ins_data_reg;
        ins_freq_next = ins_freq_reg;
        ins_acc_next  = ins_acc_reg;
        res_found_next = res_found_reg;
        res_rv_next   = res_rv_reg;
        res_tf_next   = res_tf_reg;
        stamp_next    = stamp_reg;
        cap_next      = cap_reg;
        gcap_next     = gcap_reg;
        thr_next      = thr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_found_next  = m_found_reg;
        m_tf_next     = m_tf_reg;
        m_rv_next     = m_rv_reg;
        m_cap_next    = m_cap_reg;

        m_cmd      = '0;
        m_clr_idx  = '0;
        m_wr_idx   = '0;
        m_wr_key   = key_reg;
        m_wr_data  = ins_data_reg;
        m_wr_freq  = ins_freq_reg;
        m_wr_acc   = ins_acc_reg;
        m_wr_stamp = stamp_reg;
        g_cmd      = '0;
        g_clr_idx  = '0;
        g_wr_idx   = '0;
        g_wr_stamp = stamp_reg;

        acc       = '0;
        evict     = 1'b0;
        drop      = 1'b0;
        g_slot_ok = 1'b0;
        g_slot    = '0;
        m_slot_ok = 1'b0;
        m_slot    = '0;
        stamp_a   = stamp_reg;

        if (gcap_reg == '0) begin
            g_lim = GCNT_W'(1);
        end else if (32'(gcap_reg) > GHOST_ENTRIES) begin
            g_lim = GCNT_W'(GHOST_ENTRIES);
        end else begin
            g_lim = GCNT_W'(gcap_reg);
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next      = s_tuser;
                    key_next      = s_tdata[KEY_BITS-1:0];
                    wv_next       = s_tdata[KEY_BITS +: VALUE_BITS];
                    phase_next    = 1'b0;
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg != SCNT_W'(SCAN_LEN)) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else begin
                    scan_cnt_next = '0;
                    state_next    = ST_OUT;
                    if (!phase_reg) begin
                        res_found_next = 1'b0;
                        res_rv_next    = '0;
                        res_tf_next    = 1'b0;
                        case (req_reg)
                            lfu_pkg::REQ_GET, lfu_pkg::REQ_PUT: begin
                                if (mc_hit_ok[MAIN_ENTRIES]) begin
                                    acc         = sat_inc(mc_hit_acc[MAIN_ENTRIES]);
                                    res_tf_next = 32'(acc) >= 32'(thr_reg);
                                    m_cmd.wr_en = 1'b1;
                                    m_wr_idx    = mc_hit_idx[MAIN_ENTRIES];
                                    m_wr_acc    = acc;
                                    m_wr_freq   = sat_inc(mc_hit_freq[MAIN_ENTRIES]);
                                    m_wr_stamp  = stamp_reg;
                                    stamp_next  = stamp_inc(stamp_reg);
                                    if (req_reg == lfu_pkg::REQ_PUT) begin
                                        m_wr_data = wv_reg;
                                    end else begin
                                        m_wr_data      = mc_hit_data[MAIN_ENTRIES];
                                        res_found_next = 1'b1;
                                        res_rv_next    = mc_hit_data[MAIN_ENTRIES];
                                    end
                                end else if (gc_hit_ok[GHOST_ENTRIES]) begin
                                    acc           = sat_inc(gc_hit_acc[GHOST_ENTRIES]);
                                    res_tf_next   = 32'(acc) >= 32'(thr_reg);
                                    ins_acc_next  = acc;
                                    ins_freq_next = gc_hit_freq[GHOST_ENTRIES];
                                    if (req_reg == lfu_pkg::REQ_PUT) begin
                                        ins_data_next = wv_reg;
                                    end else begin
                                        ins_data_next  = gc_hit_data[GHOST_ENTRIES];
                                        res_found_next = 1'b1;
                                        res_rv_next    = gc_hit_data[GHOST_ENTRIES];
                                    end
                                    g_cmd.clr_en = 1'b1;
                                    g_clr_idx    = gc_hit_idx[GHOST_ENTRIES];
                                    phase_next   = 1'b1;
                                    state_next   = ST_SCAN;
                                end else if (req_reg == lfu_pkg::REQ_PUT) begin
                                    ins_data_next = wv_reg;
                                    ins_freq_next = COUNT_BITS'(1);
                                    ins_acc_next  = COUNT_BITS'(1);
                                    res_tf_next   = thr_reg <= lfu_pkg::THR_BITS'(1);
                                    phase_next    = 1'b1;
                                    state_next    = ST_SCAN;
                                end
                            end
                            lfu_pkg::REQ_GROW: begin
                                if (32'(cap_reg) < MAIN_ENTRIES) begin
                                    cap_next = cap_reg + 1'b1;
                                end
                                res_found_next = 1'b1;
                            end
                            lfu_pkg::REQ_SHRINK: begin
                                if (cap_reg != '0) begin
                                    cap_next       = cap_reg - 1'b1;
                                    res_found_next = 1'b1;
                                end
                            end
                            lfu_pkg::REQ_CHECK: begin
                                res_found_next = gc_hit_ok[GHOST_ENTRIES];
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        evict = (32'(mc_cnt[MAIN_ENTRIES]) >= 32'(cap_reg)) &&
                                mc_best_ok[MAIN_ENTRIES];
                        if (evict) begin
                            m_cmd.clr_en = 1'b1;
                            m_clr_idx    = mc_best_idx[MAIN_ENTRIES];
                            drop = (gc_cnt[GHOST_ENTRIES] >= g_lim) &&
                                   gc_best_ok[GHOST_ENTRIES];
                            if (gc_free_ok[GHOST_ENTRIES]) begin
                                g_slot_ok = 1'b1;
                                if (drop && (gc_best_idx[GHOST_ENTRIES] <
                                             gc_free_idx[GHOST_ENTRIES])) begin
                                    g_slot = gc_best_idx[GHOST_ENTRIES];
                                end else begin
                                    g_slot = gc_free_idx[GHOST_ENTRIES];
                                end
                            end else if (drop) begin
                                g_slot_ok = 1'b1;
                                g_slot    = gc_best_idx[GHOST_ENTRIES];
                            end
                            g_cmd.clr_en = drop;
                            g_clr_idx    = gc_best_idx[GHOST_ENTRIES];
                            if (g_slot_ok) begin
                                g_cmd.wr_en = 1'b1;
                                g_wr_idx    = g_slot;
                                g_wr_stamp  = stamp_reg;
                                stamp_a     = stamp_inc(stamp_reg);
                            end
                        end
                        if (mc_free_ok[MAIN_ENTRIES]) begin
                            m_slot_ok = 1'b1;
                            if (evict && (mc_best_idx[MAIN_ENTRIES] <
                                          mc_free_idx[MAIN_ENTRIES])) begin
                                m_slot = mc_best_idx[MAIN_ENTRIES];
                            end else begin
                                m_slot = mc_free_idx[MAIN_ENTRIES];
                            end
                        end else if (evict) begin
                            m_slot_ok = 1'b1;
                            m_slot    = mc_best_idx[MAIN_ENTRIES];
                        end
                        stamp_next = stamp_a;
                        if (m_slot_ok) begin
                            m_cmd.wr_en = 1'b1;
                            m_wr_idx    = m_slot;
                            m_wr_stamp  = stamp_a;
                            stamp_next  = stamp_inc(stamp_a);
                        end
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_tf_next     = res_tf_reg;
                    m_rv_next     = res_rv_reg;
                    m_cap_next    = cap_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                lfu_pkg::CFG_INIT_CAP: begin
                    if (32'(cfg_data[CB-1:0]) > MAIN_ENTRIES) begin
                        cap_next = CB'(MAIN_ENTRIES);
                    end else begin
                        cap_next = cfg_data[CB-1:0];
                    end
                end
                lfu_pkg::CFG_GHOST_CAP: gcap_next = cfg_data[lfu_pkg::GCAP_BITS-1:0];
                lfu_pkg::CFG_THRESHOLD: thr_next = cfg_data[lfu_pkg::THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            phase_reg    <= 1'b0;
            stamp_reg    <= '0;
            cap_reg      <= CAP_RESET;
            gcap_reg     <= lfu_pkg::GCAP_BITS'(8);
            thr_reg      <= lfu_pkg::THR_BITS'(4);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            phase_reg    <= phase_next;
            stamp_reg    <= stamp_next;
            cap_reg      <= cap_next;
            gcap_reg     <= gcap_next;
            thr_reg      <= thr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        key_reg       <= key_next;
        wv_reg        <= wv_next;
        ins_data_reg  <= ins_data_next;
        ins_freq_reg  <= ins_freq_next;
        ins_acc_reg   <= ins_acc_next;
        res_found_reg <= res_found_next;
        res_rv_reg    <= res_rv_next;
        res_tf_reg    <= res_tf_next;
        m_found_reg   <= m_found_next;
        m_tf_reg      <= m_tf_next;
        m_rv_reg      <= m_rv_next;
        m_cap_reg     <= m_cap_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_DATA_W'({m_cap_reg, m_rv_reg});
    assign m_tuser   = {m_tf_reg, m_found_reg};

    a_cap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cap_reg) <= MAIN_ENTRIES)
        else $error("capacity above table size");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN && scan_cnt_reg == '0))
        else $error("accepted transaction did not start a scan");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scan_cnt_reg) <= SCAN_LEN)
        else $error("scan counter overran chain length");

endmodule

`default_nettype wire

// File: design/lfu_cell.sv
// One entry of the main store or the ghost list, plus one registered stage of
// the scan chain (count, first free, first match, least-frequent/oldest).
// Depends on lfu_pkg.
`default_nettype none

module lfu_cell #(
    parameter int ENTRIES    = lfu_pkg::MAIN_ENTRIES_DEF,
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter bit USE_FREQ   = 1'b1,
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  lfu_pkg::cell_cmd_t               cmd,
    input  wire  [IDX_W-1:0]                 clr_idx,
    input  wire  [IDX_W-1:0]                 wr_idx,
    input  wire  [KEY_BITS-1:0]              wr_key,
    input  wire  [VALUE_BITS-1:0]            wr_data,
    input  wire  [COUNT_BITS-1:0]            wr_freq,
    input  wire  [COUNT_BITS-1:0]            wr_acc,
    input  wire  [lfu_pkg::STAMP_BITS-1:0]   wr_stamp,
    input  wire  [KEY_BITS-1:0]              look_key,
    input  wire  [CNT_W-1:0]                 up_cnt,
    input  wire                              up_free_ok,
    input  wire  [IDX_W-1:0]                 up_free_idx,
    input  wire                              up_hit_ok,
    input  wire  [IDX_W-1:0]                 up_hit_idx,
    input  wire  [VALUE_BITS-1:0]            up_hit_data,
    input  wire  [COUNT_BITS-1:0]            up_hit_freq,
    input  wire  [COUNT_BITS-1:0]            up_hit_acc,
    input  wire                              up_best_ok,
    input  wire  [IDX_W-1:0]                 up_best_idx,
    input  wire  [KEY_BITS-1:0]              up_best_key,
    input  wire  [VALUE_BITS-1:0]            up_best_data,
    input  wire  [COUNT_BITS-1:0]            up_best_freq,
    input  wire  [COUNT_BITS-1:0]            up_best_acc,
    input  wire  [lfu_pkg::STAMP_BITS-1:0]   up_best_stamp,
    output logic [CNT_W-1:0]                 dn_cnt,
    output logic                             dn_free_ok,
    output logic [IDX_W-1:0]                 dn_free_idx,
    output logic                             dn_hit_ok,
    output logic [IDX_W-1:0]                 dn_hit_idx,
    output logic [VALUE_BITS-1:0]            dn_hit_data,
    output logic [COUNT_BITS-1:0]            dn_hit_freq,
    output logic [COUNT_BITS-1:0]            dn_hit_acc,
    output logic                             dn_best_ok,
    output logic [IDX_W-1:0]                 dn_best_idx,
    output logic [KEY_BITS-1:0]              dn_best_key,
    output logic [VALUE_BITS-1:0]            dn_best_data,
    output logic [COUNT_BITS-1:0]            dn_best_freq,
    output logic [COUNT_BITS-1:0]            dn_best_acc,
    output logic [lfu_pkg::STAMP_BITS-1:0]   dn_best_stamp
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                            valid_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic [VALUE_BITS-1:0]           data_reg;
    logic [COUNT_BITS-1:0]           freq_reg;
    logic [COUNT_BITS-1:0]           acc_reg;
    logic [lfu_pkg::STAMP_BITS-1:0]  stamp_reg;

    logic [CNT_W-1:0]                cnt_reg;
    logic                            free_ok_reg;
    logic [IDX_W-1:0]                free_idx_reg;
    logic                            hit_ok_reg;
    logic [IDX_W-1:0]                hit_idx_reg;
    logic [VALUE_BITS-1:0]           hit_data_reg;
    logic [COUNT_BITS-1:0]           hit_freq_reg;
    logic [COUNT_BITS-1:0]           hit_acc_reg;
    logic                            best_ok_reg;
    logic [IDX_W-1:0]                best_idx_reg;
    logic [KEY_BITS-1:0]             best_key_reg;
    logic [VALUE_BITS-1:0]           best_data_reg;
    logic [COUNT_BITS-1:0]           best_freq_reg;
    logic [COUNT_BITS-1:0]           best_acc_reg;
    logic [lfu_pkg::STAMP_BITS-1:0]  best_stamp_reg;

    logic wr_here;
    logic hit_here;
    logic older;
    logic take_best;

    assign wr_here  = cmd.wr_en && (wr_idx == MY_IDX);
    assign hit_here = valid_reg && (key_reg == look_key);

    always_comb begin
        if (USE_FREQ) begin
            older = (freq_reg < up_best_freq) ||
                    ((freq_reg == up_best_freq) && (stamp_reg < up_best_stamp));
        end else begin
            older = stamp_reg < up_best_stamp;
        end
        take_best = valid_reg && (!up_best_ok || older);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_here) begin
            valid_reg <= 1'b1;
        end else if (cmd.clr_en && (clr_idx == MY_IDX)) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here) begin
            key_reg   <= wr_key;
            data_reg  <= wr_data;
            freq_reg  <= wr_freq;
            acc_reg   <= wr_acc;
            stamp_reg <= wr_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= up_cnt + CNT_W'(valid_reg);
        if (up_free_ok || valid_reg) begin
            free_ok_reg  <= up_free_ok;
            free_idx_reg <= up_free_idx;
        end else begin
            free_ok_reg  <= 1'b1;
            free_idx_reg <= MY_IDX;
        end
        if (up_hit_ok || !hit_here) begin
            hit_ok_reg   <= up_hit_ok;
            hit_idx_reg  <= up_hit_idx;
            hit_data_reg <= up_hit_data;
            hit_freq_reg <= up_hit_freq;
            hit_acc_reg  <= up_hit_acc;
        end else begin
            hit_ok_reg   <= 1'b1;
            hit_idx_reg  <= MY_IDX;
            hit_data_reg <= data_reg;
            hit_freq_reg <= freq_reg;
            hit_acc_reg  <= acc_reg;
        end
        if (take_best) begin
            best_ok_reg    <= 1'b1;
            best_idx_reg   <= MY_IDX;
            best_key_reg   <= key_reg;
            best_data_reg  <= data_reg;
            best_freq_reg  <= freq_reg;
            best_acc_reg   <= acc_reg;
            best_stamp_reg <= stamp_reg;
        end else begin
            best_ok_reg    <= up_best_ok;
            best_idx_reg   <= up_best_idx;
            best_key_reg   <= up_best_key;
            best_data_reg  <= up_best_data;
            best_freq_reg  <= up_best_freq;
            best_acc_reg   <= up_best_acc;
            best_stamp_reg <= up_best_stamp;
        end
    end

    assign dn_cnt        = cnt_reg;
    assign dn_free_ok    = free_ok_reg;
    assign dn_free_idx   = free_idx_reg;
    assign dn_hit_ok     = hit_ok_reg;
    assign dn_hit_idx    = hit_idx_reg;
    assign dn_hit_data   = hit_data_reg;
    assign dn_hit_freq   = hit_freq_reg;
    assign dn_hit_acc    = hit_acc_reg;
    assign dn_best_ok    = best_ok_reg;
    assign dn_best_idx   = best_idx_reg;
    assign dn_best_key   = best_key_reg;
    assign dn_best_data  = best_data_reg;
    assign dn_best_freq  = best_freq_reg;
    assign dn_best_acc   = best_acc_reg;
    assign dn_best_stamp = best_stamp_reg;

endmodule

`default_nettype wire
